>>> design/i2cm_pkg.sv
// Shared types and codes of the I2C master byte engine.
package i2cm_pkg;

    // Operation codes carried on the input tuser field.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_ADDR  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_STOP  = 3'd4;

    // Status codes carried on the output tuser field.
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_BUSY      = 3'd1;
    localparam logic [2:0] ST_DONE_ACK  = 3'd2;
    localparam logic [2:0] ST_DONE_NACK = 3'd3;
    localparam logic [2:0] ST_ACCEPTED  = 3'd4;
    localparam logic [2:0] ST_REJECTED  = 3'd5;

    // Quarter-bit tick counts.
    localparam logic [5:0] START_TICKS = 6'd4;
    localparam logic [5:0] DATA_TICKS  = 6'd32;
    localparam logic [5:0] BYTE_TICKS  = 6'd36;
    localparam logic [5:0] LAST_BYTE_TICK = 6'd35;

    typedef struct packed {
        logic [2:0] operation;
        logic       sda_level;
        logic [6:0] slave_address;
        logic       read_flag;
        logic [7:0] byte_value;
        logic       stop_after;
    } t_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [2:0] status;
        logic [7:0] read_byte;
    } t_result;

endpackage

>>> design/i2cm_core.sv
// Command state and quarter-bit sequencer of the I2C master byte engine.
module i2cm_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  i2cm_pkg::t_item   i_item,
    output i2cm_pkg::t_result o_result
);

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_ADDR  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_STOP  = 3'd4
    } t_cmd;

    t_cmd       r_cmd,   n_cmd;
    logic [5:0] r_phase, n_phase;
    logic [7:0] r_shift, n_shift;
    logic       r_pstop, n_pstop;
    logic       r_ack,   n_ack;
    logic       r_scl,   n_scl;
    logic       r_sda,   n_sda;

    logic [5:0] w_base;
    logic [5:0] w_k;
    logic [1:0] w_sidx;
    logic [1:0] w_stop_q;
    logic       w_reading;
    logic       w_is_stop;
    logic       w_done;
    logic [2:0] w_status;
    logic [7:0] w_rbyte;

    assign w_base    = (r_cmd == CMD_ADDR) ? i2cm_pkg::START_TICKS : 6'd0;
    assign w_k       = r_phase - w_base;
    assign w_sidx    = w_k[1:0] - i2cm_pkg::BYTE_TICKS[1:0];
    assign w_reading = (r_cmd == CMD_READ);
    assign w_is_stop = (r_cmd == CMD_STOP);
    assign w_stop_q  = w_is_stop ? r_phase[1:0] : w_sidx;

    always_comb begin
        n_cmd    = r_cmd;
        n_phase  = r_phase;
        n_shift  = r_shift;
        n_pstop  = r_pstop;
        n_ack    = r_ack;
        n_scl    = r_scl;
        n_sda    = r_sda;
        w_done   = 1'b0;
        w_status = i2cm_pkg::ST_IDLE;
        w_rbyte  = 8'd0;

        if (i_item.operation != i2cm_pkg::OP_TICK) begin
            if (r_cmd != CMD_IDLE || i_item.operation > i2cm_pkg::OP_STOP) begin
                w_status = i2cm_pkg::ST_REJECTED;
            end else begin
                w_status = i2cm_pkg::ST_ACCEPTED;
                n_cmd    = t_cmd'(i_item.operation);
                n_phase  = 6'd0;
                n_ack    = 1'b0;
                n_pstop  = i_item.stop_after;
                case (i_item.operation)
                    i2cm_pkg::OP_ADDR:  n_shift = {i_item.slave_address, i_item.read_flag};
                    i2cm_pkg::OP_WRITE: n_shift = i_item.byte_value;
                    default:            n_shift = 8'd0;
                endcase
            end
        end else if (r_cmd == CMD_IDLE) begin
            w_status = i2cm_pkg::ST_IDLE;
        end else begin
            w_status = i2cm_pkg::ST_BUSY;
            if (!w_is_stop && r_phase < w_base) begin
                // START: release SDA, raise SCL, pull SDA, pull SCL
                case (r_phase[1:0])
                    2'd0:    n_sda = 1'b1;
                    2'd1:    n_scl = 1'b1;
                    2'd2:    n_sda = 1'b0;
                    default: n_scl = 1'b0;
                endcase
            end else if (!w_is_stop && w_k < i2cm_pkg::BYTE_TICKS) begin
                if (w_k < i2cm_pkg::DATA_TICKS) begin
                    case (w_k[1:0])
                        2'd0: n_sda = w_reading ? 1'b1 : r_shift[7];
                        2'd1: n_scl = 1'b1;
                        2'd2: begin
                            if (w_reading) n_shift = {r_shift[6:0], i_item.sda_level};
                        end
                        default: begin
                            n_scl = 1'b0;
                            if (!w_reading) n_shift = {r_shift[6:0], 1'b0};
                        end
                    endcase
                end else begin
                    // acknowledge slot
                    case (w_k[1:0])
                        2'd0: n_sda = w_reading ? r_pstop : 1'b1;
                        2'd1: n_scl = 1'b1;
                        2'd2: begin
                            if (!w_reading) n_ack = !i_item.sda_level;
                        end
                        default: n_scl = 1'b0;
                    endcase
                end
                if (w_k == i2cm_pkg::LAST_BYTE_TICK) begin
                    if (!w_reading && !r_ack) begin
                        w_done   = 1'b1;
                        w_status = i2cm_pkg::ST_DONE_NACK;
                    end else if (!r_pstop) begin
                        w_done   = 1'b1;
                        w_status = i2cm_pkg::ST_DONE_ACK;
                    end
                end
            end else begin
                // STOP: pull SDA, raise SCL, release SDA
                case (w_stop_q)
                    2'd0: n_sda = 1'b0;
                    2'd1: n_scl = 1'b1;
                    default: begin
                        n_sda    = 1'b1;
                        w_done   = 1'b1;
                        w_status = i2cm_pkg::ST_DONE_ACK;
                    end
                endcase
            end

            if (w_done) begin
                if (w_reading) w_rbyte = r_shift;
                n_cmd   = CMD_IDLE;
                n_phase = 6'd0;
            end else begin
                n_phase = r_phase + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd   <= CMD_IDLE;
            r_phase <= 6'd0;
            r_shift <= 8'd0;
            r_pstop <= 1'b0;
            r_ack   <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
        end else if (i_step) begin
            r_cmd   <= n_cmd;
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_pstop <= n_pstop;
            r_ack   <= n_ack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
        end
    end

    assign o_result = '{scl_out:   n_scl,
                        sda_out:   n_sda,
                        status:    w_status,
                        read_byte: w_rbyte};

endmodule

>>> design/i2c_master_byte_engine.sv
// Top level of the I2C master byte engine: input register, sequencer, result register.
//
// Single-master I2C engine with 7-bit addressing, advanced by quarter-bit
// tick items. Every input transfer yields exactly one result transfer. When
// idle, a command item (start plus address, write byte, read byte, stop only)
// is accepted with status ACCEPTED; a command while busy, or an unknown
// operation code, is answered with REJECTED and changes nothing. Each tick item
// then runs one quarter-bit phase and reports the SCL and SDA levels to drive
// (SDA 1 means released): START takes 4 ticks, each byte 36 (8 data bits and
// the acknowledge slot, 4 ticks each), STOP 3. A NACK on an address or write
// byte ends the command without STOP; otherwise stop_after appends STOP, and
// for reads it also answers the byte with NACK. The received byte appears in
// the result that carries the done status of a read. Throughput is one
// transfer per clock while results are taken; a transfer passes through the
// input register, then the result register, and the command state in the
// sequencer, updated on each step, is what sets that rate. The result register
// frees the input side: one more item is accepted while a result waits, after
// which the input stalls until the result is taken.
module i2c_master_byte_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [0] sda_level, [7:1] slave_address, [8] read_flag, [16:9] byte_value,
    // [17] stop_after, [23:18] zero
    input  logic [23:0] i_s_axis_tdata,
    // [2:0] operation
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] scl_out, [1] sda_out, [9:2] read_byte, [15:10] zero
    output logic [15:0] o_m_axis_tdata,
    // [2:0] status
    output logic [2:0]  o_m_axis_tuser
);

    logic              r_in_valid;
    i2cm_pkg::t_item   r_in_item;
    logic              r_out_valid;
    i2cm_pkg::t_result r_out;

    logic              w_in_xfer;
    logic              w_out_free;
    logic              w_advance;
    i2cm_pkg::t_result w_result;

    // Result register is free when empty or being drained this cycle.
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_advance       = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;

    // Capture the item into the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_item <= '{operation:     i_s_axis_tuser,
                           sda_level:     i_s_axis_tdata[0],
                           slave_address: i_s_axis_tdata[7:1],
                           read_flag:     i_s_axis_tdata[8],
                           byte_value:    i_s_axis_tdata[16:9],
                           stop_after:    i_s_axis_tdata[17]};
        end
    end

    // Run one step of the sequencer per item moved into the result register.
    i2cm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    // Hold the result until the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out.read_byte, r_out.sda_out, r_out.scl_out};
    assign o_m_axis_tuser  = r_out.status;

    // A received byte is only reported together with a done status.
    a_rbyte_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.read_byte != 8'd0) |-> (r_out.status == i2cm_pkg::ST_DONE_ACK))
        else $error("read byte reported without done status");

    // A held input item is never dropped while the result side is stalled.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_item)))
        else $error("input item lost while stalled");

    // Every item leaving the input register lands in the result register.
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("advanced item did not reach the result register");

endmodule

>>> dv/tb_i2c_master_byte_engine.sv
// Self-checking testbench for the I2C master byte engine with its own bus predictor.
module tb_i2c_master_byte_engine;

    // Bus-level timing of the tb's own view of the engine.
    localparam int          STOP_LEN     = 3;
    localparam int          OP_CODE_MAX  = 7;       // top of the 3-bit operation space
    localparam logic [2:0]  NO_CMD       = i2cm_pkg::OP_TICK; // engine idle, no command held
    localparam int          RAND_ITEMS   = 240;
    localparam int          QUIET_LIMIT  = 3000;    // cycles with no transfer on either side
    localparam int          LONG_HOLD    = 120;     // receiver back-pressure stretch
    localparam int          DRAIN_CYCLES = 8;

    typedef struct {
        i2cm_pkg::t_item   it;
        int                reps;   // how many times the row is offered back to back
        bit                typed;  // expected result typed in below instead of predicted
        i2cm_pkg::t_result want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;   // [0] sda_level, [7:1] slave_address, [8] read_flag,
                                   // [16:9] byte_value, [17] stop_after, [23:18] zero
    logic [2:0]  i_s_axis_tuser;   // [2:0] operation
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [15:0] o_m_axis_tdata;   // [0] scl_out, [1] sda_out, [9:2] read_byte, [15:10] zero
    logic [2:0]  o_m_axis_tuser;   // [2:0] status

    i2c_master_byte_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Predicted engine state; reset values apply from time zero since reset is
    // asserted once, before the first transfer.
    logic [2:0] pred_cmd       = NO_CMD;
    logic [5:0] pred_phase     = '0;
    logic [7:0] pred_shift     = '0;
    logic       pred_stop_pend = 1'b0;
    logic       pred_acked     = 1'b0;
    logic       pred_scl       = 1'b1;
    logic       pred_sda       = 1'b1;

    i2cm_pkg::t_result expected_levels_q[$];
    int                errors = 0;

    // Item currently on the input bus, with an optional typed expectation.
    i2cm_pkg::t_item   drv_item;
    bit                drv_typed;
    i2cm_pkg::t_result drv_want;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One STOP quarter-bit; returns 1 on the phase that releases SDA.
    function automatic bit stop_quarter(input logic [5:0] q);
        if (q == 6'd0) begin
            pred_sda = 1'b0;
            return 1'b0;
        end
        if (q == 6'd1) begin
            pred_scl = 1'b1;
            return 1'b0;
        end
        pred_sda = 1'b1;
        return 1'b1;
    endfunction

    function automatic i2cm_pkg::t_result predict_bus_phase(input i2cm_pkg::t_item it);
        i2cm_pkg::t_result r;
        logic [5:0] base;
        logic [5:0] k;
        logic [1:0] q;
        logic       rd;
        logic       fin;
        logic [2:0] st;
        logic [7:0] rb;
        rb = '0;
        if (it.operation != i2cm_pkg::OP_TICK) begin
            // Commands only land on an idle engine with a known code.
            if (pred_cmd != NO_CMD || it.operation > i2cm_pkg::OP_STOP) begin
                st = i2cm_pkg::ST_REJECTED;
            end else begin
                pred_cmd       = it.operation;
                pred_phase     = '0;
                pred_acked     = 1'b0;
                pred_stop_pend = it.stop_after;
                if (it.operation == i2cm_pkg::OP_ADDR)
                    pred_shift = {it.slave_address, it.read_flag};
                else if (it.operation == i2cm_pkg::OP_WRITE)
                    pred_shift = it.byte_value;
                else
                    pred_shift = '0;
                st = i2cm_pkg::ST_ACCEPTED;
            end
        end else if (pred_cmd == NO_CMD) begin
            st = i2cm_pkg::ST_IDLE;
        end else begin
            rd   = (pred_cmd == i2cm_pkg::OP_READ);
            fin  = 1'b0;
            st   = i2cm_pkg::ST_BUSY;
            base = (pred_cmd == i2cm_pkg::OP_ADDR) ? i2cm_pkg::START_TICKS : 6'd0;
            if (pred_cmd == i2cm_pkg::OP_STOP) begin
                fin = stop_quarter(pred_phase);
                if (fin) st = i2cm_pkg::ST_DONE_ACK;
            end else if (pred_phase < base) begin
                // START: SDA high, SCL high, SDA low, SCL low.
                case (pred_phase[1:0])
                    2'd0: pred_sda = 1'b1;
                    2'd1: pred_scl = 1'b1;
                    2'd2: pred_sda = 1'b0;
                    default: pred_scl = 1'b0;
                endcase
            end else if (pred_phase < base + i2cm_pkg::BYTE_TICKS) begin
                k = pred_phase - base;
                q = k[1:0];
                if (k < i2cm_pkg::DATA_TICKS) begin
                    case (q)
                        2'd0: pred_sda = rd ? 1'b1 : pred_shift[7];
                        2'd1: pred_scl = 1'b1;
                        2'd2: if (rd) pred_shift = {pred_shift[6:0], it.sda_level};
                        default: begin
                            pred_scl = 1'b0;
                            if (!rd) pred_shift = {pred_shift[6:0], 1'b0};
                        end
                    endcase
                end else begin
                    // Acknowledge slot: a read answers NACK when a STOP follows.
                    case (q)
                        2'd0: pred_sda = rd ? pred_stop_pend : 1'b1;
                        2'd1: pred_scl = 1'b1;
                        2'd2: if (!rd) pred_acked = ~it.sda_level;
                        default: pred_scl = 1'b0;
                    endcase
                end
                if (k == i2cm_pkg::LAST_BYTE_TICK) begin
                    if (!rd && !pred_acked) begin
                        fin = 1'b1;
                        st  = i2cm_pkg::ST_DONE_NACK;
                    end else if (!pred_stop_pend) begin
                        fin = 1'b1;
                        st  = i2cm_pkg::ST_DONE_ACK;
                    end
                end
            end else begin
                fin = stop_quarter(pred_phase - base - i2cm_pkg::BYTE_TICKS);
                if (fin) st = i2cm_pkg::ST_DONE_ACK;
            end
            if (fin) begin
                if (rd) rb = pred_shift;
                pred_cmd   = NO_CMD;
                pred_phase = '0;
            end else begin
                pred_phase = pred_phase + 6'd1;
            end
        end
        r.scl_out   = pred_scl;
        r.sda_out   = pred_sda;
        r.status    = st;
        r.read_byte = rb;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, receiver
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure at the current rate, plus a long hold-off
    // whenever the main sequence raises a request.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready = 1'b0;
            end else begin
                i_m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: predict on input transfer, check on output transfer
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        i2cm_pkg::t_result pred;
        i2cm_pkg::t_result want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                // Advance the predictor even on typed rows to keep its state in step.
                pred = predict_bus_phase(drv_item);
                expected_levels_q.push_back(drv_typed ? drv_want : pred);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_levels_q.size() == 0) begin
                    errors++;
                    $display("%0t: result transfer with nothing expected, actual %h/%h",
                             $time, o_m_axis_tuser, o_m_axis_tdata);
                end else begin
                    want = expected_levels_q.pop_front();
                    check_field("scl_out",   8'(want.scl_out),   8'(o_m_axis_tdata[0]));
                    check_field("sda_out",   8'(want.sda_out),   8'(o_m_axis_tdata[1]));
                    check_field("read_byte", want.read_byte,     o_m_axis_tdata[9:2]);
                    check_field("status",    8'(want.status),    8'(o_m_axis_tuser));
                end
            end
        end
    end

    // Watchdog: stop a run that has stopped moving.
    always @(posedge i_clk) begin
        int quiet;
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                     || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("tb_i2c_master_byte_engine failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one item and hold it until the transfer; returns at the next falling edge.
    task automatic offer(input i2cm_pkg::t_item it, input bit typed,
                         input i2cm_pkg::t_result want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        drv_item        = it;
        drv_typed       = typed;
        drv_want        = want;
        i_s_axis_tdata  = {6'd0, it.stop_after, it.byte_value, it.read_flag,
                           it.slave_address, it.sda_level};
        i_s_axis_tuser  = it.operation;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    function automatic i2cm_pkg::t_item rand_item(input logic [2:0] op);
        i2cm_pkg::t_item it;
        it.operation     = op;
        it.sda_level     = 1'($urandom_range(0, 1));
        it.slave_address = 7'($urandom);
        it.read_flag     = 1'($urandom_range(0, 1));
        it.byte_value    = 8'($urandom);
        it.stop_after    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_dir_row mk_row(input logic [2:0] op, input logic sda,
                                        input logic [6:0] addr, input logic rd,
                                        input logic [7:0] data, input logic stp,
                                        input int reps, input bit typed,
                                        input logic scl_o, input logic sda_o,
                                        input logic [2:0] st, input logic [7:0] rb);
        t_dir_row r;
        r.it.operation     = op;
        r.it.sda_level     = sda;
        r.it.slave_address = addr;
        r.it.read_flag     = rd;
        r.it.byte_value    = data;
        r.it.stop_after    = stp;
        r.reps             = reps;
        r.typed            = typed;
        r.want.scl_out     = scl_o;
        r.want.sda_out     = sda_o;
        r.want.status      = st;
        r.want.read_byte   = rb;
        return r;
    endfunction

    initial begin
        t_dir_row          dir_q[$];
        t_dir_row          row;
        i2cm_pkg::t_item   it;
        i2cm_pkg::t_result none;
        int                rand_sent;
        int                sel;
        int                n_ticks;
        int                phase_no;
        logic [2:0]        op;

        none              = '0;
        i_rst_n           = 1'b0;
        i_s_axis_tvalid   = 1'b0;
        i_s_axis_tdata    = '0;
        i_s_axis_tuser    = i2cm_pkg::OP_TICK;
        drv_item          = '0;
        drv_typed         = 1'b0;
        drv_want          = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Phase one of idling: sender idles lightly, receiver heavily.
        send_idle_pct = 22;
        recv_idle_pct = 71;

        // Directed rows: op, sda, addr, rd, byte, stop, reps, typed, scl, sda, status, rbyte.
        // Idle ticks and unknown codes on a fresh engine leave the bus released.
        dir_q.push_back(mk_row(i2cm_pkg::OP_TICK, 0, 7'h00, 0, 8'h00, 0, 1, 1, 1, 1,
                               i2cm_pkg::ST_IDLE, 0));
        dir_q.push_back(mk_row(3'd5, 1, 7'h7f, 1, 8'hff, 1, 1, 1, 1, 1,
                               i2cm_pkg::ST_REJECTED, 0));
        dir_q.push_back(mk_row(3'd7, 0, 7'h00, 0, 8'h00, 0, 1, 1, 1, 1,
                               i2cm_pkg::ST_REJECTED, 0));
        // Stop-only command, with a command thrown at it while busy.
        dir_q.push_back(mk_row(i2cm_pkg::OP_STOP, 0, 7'h00, 0, 8'h00, 0, 1, 1, 1, 1,
                               i2cm_pkg::ST_ACCEPTED, 0));
        dir_q.push_back(mk_row(i2cm_pkg::OP_ADDR, 0, 7'h7f, 1, 8'h00, 1, 1, 1, 1, 1,
                               i2cm_pkg::ST_REJECTED, 0));
        dir_q.push_back(mk_row(i2cm_pkg::OP_TICK, 1, 7'h00, 0, 8'h00, 0, 1, 1, 1, 0,
                               i2cm_pkg::ST_BUSY, 0));
        dir_q.push_back(mk_row(i2cm_pkg::OP_TICK, 1, 7'h00, 0, 8'h00, 0, 1, 1, 1, 0,
                               i2cm_pkg::ST_BUSY, 0));
        dir_q.push_back(mk_row(i2cm_pkg::OP_TICK, 1, 7'h00, 0, 8'h00, 0, 1, 1, 1, 1,
                               i2cm_pkg::ST_DONE_ACK, 0));
        dir_q.push_back(mk_row(i2cm_pkg::OP_TICK, 1, 7'h00, 0, 8'h00, 0, 1, 1, 1, 1,
                               i2cm_pkg::ST_IDLE, 0));
        // Top address with read direction; busy engine rejects a write and a bad code.
        dir_q.push_back(mk_row(i2cm_pkg::OP_ADDR, 0, 7'h7f, 1, 8'h00, 0, 1, 1, 1, 1,
                               i2cm_pkg::ST_ACCEPTED, 0));
        dir_q.push_back(mk_row(i2cm_pkg::OP_WRITE, 1, 7'h00, 0, 8'hff, 1, 1, 1, 1, 1,
                               i2cm_pkg::ST_REJECTED, 0));
        dir_q.push_back(mk_row(3'd6, 0, 7'h00, 0, 8'h00, 0, 1, 1, 1, 1,
                               i2cm_pkg::ST_REJECTED, 0));
        dir_q.push_back(mk_row(i2cm_pkg::OP_TICK, 0, 7'h00, 0, 8'h00, 0, 40, 0, 0, 0,
                               i2cm_pkg::ST_IDLE, 0));
        // Read of all ones answered with ACK, no STOP.
        dir_q.push_back(mk_row(i2cm_pkg::OP_READ, 0, 7'h00, 0, 8'h00, 0, 1, 0, 0, 0,
                               i2cm_pkg::ST_IDLE, 0));
        dir_q.push_back(mk_row(i2cm_pkg::OP_TICK, 1, 7'h00, 0, 8'h00, 0, 36, 0, 0, 0,
                               i2cm_pkg::ST_IDLE, 0));
        // Address zero, write direction, ACKed and followed by STOP.
        dir_q.push_back(mk_row(i2cm_pkg::OP_ADDR, 0, 7'h00, 0, 8'h00, 1, 1, 0, 0, 0,
                               i2cm_pkg::ST_IDLE, 0));
        dir_q.push_back(mk_row(i2cm_pkg::OP_TICK, 0, 7'h00, 0, 8'h00, 0, 43, 0, 0, 0,
                               i2cm_pkg::ST_IDLE, 0));
        // Write of zero that the target NACKs: ends without STOP.
        dir_q.push_back(mk_row(i2cm_pkg::OP_WRITE, 0, 7'h00, 0, 8'h00, 0, 1, 0, 0, 0,
                               i2cm_pkg::ST_IDLE, 0));
        dir_q.push_back(mk_row(i2cm_pkg::OP_TICK, 1, 7'h00, 0, 8'h00, 0, 36, 0, 0, 0,
                               i2cm_pkg::ST_IDLE, 0));
        // Write of all ones, ACKed, then STOP.
        dir_q.push_back(mk_row(i2cm_pkg::OP_WRITE, 0, 7'h00, 0, 8'hff, 1, 1, 0, 0, 0,
                               i2cm_pkg::ST_IDLE, 0));
        dir_q.push_back(mk_row(i2cm_pkg::OP_TICK, 0, 7'h00, 0, 8'h00, 0, 39, 0, 0, 0,
                               i2cm_pkg::ST_IDLE, 0));
        // Last read: NACK then STOP, byte of zeros, still reports done ack.
        dir_q.push_back(mk_row(i2cm_pkg::OP_READ, 0, 7'h00, 0, 8'h00, 1, 1, 0, 0, 0,
                               i2cm_pkg::ST_IDLE, 0));
        dir_q.push_back(mk_row(i2cm_pkg::OP_TICK, 0, 7'h00, 0, 8'h00, 0, 39, 0, 0, 0,
                               i2cm_pkg::ST_IDLE, 0));
        // Address NACK with stop_after set: no STOP follows, then idle ticks.
        dir_q.push_back(mk_row(i2cm_pkg::OP_ADDR, 0, 7'h55, 0, 8'h00, 1, 1, 0, 0, 0,
                               i2cm_pkg::ST_IDLE, 0));
        dir_q.push_back(mk_row(i2cm_pkg::OP_TICK, 1, 7'h2a, 1, 8'h5a, 1, 43, 0, 0, 0,
                               i2cm_pkg::ST_IDLE, 0));

        foreach (dir_q[i]) begin
            row = dir_q[i];
            repeat (row.reps) offer(row.it, row.typed, row.want);
        end

        // Random part: mostly complete commands with enough ticks to run them out,
        // some stray commands mid-flight and a few idle ticks or bad codes.
        rand_sent = 0;
        phase_no  = 0;
        while (rand_sent < RAND_ITEMS) begin
            if (phase_no == 0 && rand_sent >= RAND_ITEMS / 3) begin
                phase_no      = 1;
                send_idle_pct = 71;
                recv_idle_pct = 22;
            end else if (phase_no == 1 && rand_sent >= 2 * RAND_ITEMS / 3) begin
                // No idling; the long hold-off lets the engine fill and stall its input.
                phase_no      = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_req++;
            end

            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                op = (sel < 4) ? i2cm_pkg::OP_TICK
                               : 3'($urandom_range(i2cm_pkg::OP_STOP + 1, OP_CODE_MAX));
                offer(rand_item(op), 1'b0, none);
                rand_sent++;
                continue;
            end
            op = (sel < 35) ? i2cm_pkg::OP_ADDR :
                 (sel < 60) ? i2cm_pkg::OP_WRITE :
                 (sel < 85) ? i2cm_pkg::OP_READ : i2cm_pkg::OP_STOP;
            offer(rand_item(op), 1'b0, none);
            rand_sent++;

            case (op)
                i2cm_pkg::OP_ADDR:
                    n_ticks = i2cm_pkg::START_TICKS + i2cm_pkg::BYTE_TICKS + STOP_LEN;
                i2cm_pkg::OP_STOP: n_ticks = STOP_LEN;
                default: n_ticks = i2cm_pkg::BYTE_TICKS + STOP_LEN;
            endcase
            n_ticks += $urandom_range(0, 2);

            for (int t = 0; t < n_ticks; t++) begin
                if ($urandom_range(0, 99) < 3) begin
                    offer(rand_item(3'($urandom_range(i2cm_pkg::OP_ADDR, OP_CODE_MAX))),
                          1'b0, none);
                    rand_sent++;
                end
                // Lean toward a low line so most acknowledge slots see ACK.
                it           = rand_item(i2cm_pkg::OP_TICK);
                it.sda_level = ($urandom_range(0, 99) < 35);
                offer(it, 1'b0, none);
                rand_sent++;
            end
        end

        // Drop valid, drain outstanding results, then let stragglers arrive over DRAIN_CYCLES.
        i_s_axis_tvalid = 1'b0;
        while (expected_levels_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("tb_i2c_master_byte_engine passed");
        else
            $display("tb_i2c_master_byte_engine failed");
        $finish;
    end

endmodule
